@@ sv/cpbc_pkg.sv @@
// package for the counter pattern bit-error checker
// holds the word and lane sizes, default total width and the lane result type
// no dependencies
package cpbc_pkg;

  localparam int SYM_COUNT       = 5;
  localparam int WORD_BITS       = 10;
  localparam int SAMPLE_W        = 16;
  localparam int ERR_W           = 4;
  localparam int OUT_TOTAL_W     = 32;
  localparam int TOTAL_WIDTH_DEF = 32;

  typedef logic [WORD_BITS-1:0]       word_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ERR_W-1:0]           werr_t;
  typedef logic [OUT_TOTAL_W-1:0]     out_total_t;

  // what one symbol lane found: decided bits, expected bits, mismatches
  typedef struct packed {
    logic [1:0] rx_bits;
    logic [1:0] exp_bits;
    logic [1:0] errs;
  } lane_res_t;

endpackage

@@ sv/cpbc_if.sv @@
// channel interfaces for the counter pattern bit-error checker
// symbol input channel and result channel, valid/ready with payload
// depends on cpbc_pkg
interface cpbc_in_if import cpbc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sym0_i;
  sample_t sym0_q;
  sample_t sym1_i;
  sample_t sym1_q;
  sample_t sym2_i;
  sample_t sym2_q;
  sample_t sym3_i;
  sample_t sym3_q;
  sample_t sym4_i;
  sample_t sym4_q;

  modport source (output valid, output sym0_i, output sym0_q, output sym1_i, output sym1_q,
                  output sym2_i, output sym2_q, output sym3_i, output sym3_q,
                  output sym4_i, output sym4_q, input ready);
  modport sink (input valid, input sym0_i, input sym0_q, input sym1_i, input sym1_q,
                input sym2_i, input sym2_q, input sym3_i, input sym3_q,
                input sym4_i, input sym4_q, output ready);
endinterface

interface cpbc_out_if import cpbc_pkg::*; ();
  logic       valid;
  logic       ready;
  word_t      received_word;
  word_t      expected_word;
  werr_t      word_errors;
  logic       resynced;
  out_total_t error_total;
  out_total_t bit_total;

  modport source (output valid, output received_word, output expected_word,
                  output word_errors, output resynced, output error_total,
                  output bit_total, input ready);
  modport sink (input valid, input received_word, input expected_word,
                input word_errors, input resynced, input error_total,
                input bit_total, output ready);
endinterface

@@ sv/cpbc_lane.sv @@
// one symbol lane: hard decision of an I/Q pair and compare to expected bits
// depends on cpbc_pkg
module cpbc_lane import cpbc_pkg::*; (
  input  sample_t    samp_i,
  input  sample_t    samp_q,
  input  logic [1:0] index_bits,
  input  logic       first_seen,
  output lane_res_t  res
);

  logic [1:0] rx_bits;
  logic [1:0] exp_bits;
  logic [1:0] diff;

  // sign bit clear (zero included) decides to 1
  assign rx_bits  = {~samp_i[SAMPLE_W-1], ~samp_q[SAMPLE_W-1]};
  // first slot compares the word against itself
  assign exp_bits = first_seen ? index_bits : rx_bits;
  assign diff     = rx_bits ^ exp_bits;

  assign res.rx_bits  = rx_bits;
  assign res.exp_bits = exp_bits;
  assign res.errs     = {1'b0, diff[1]} + {1'b0, diff[0]};

endmodule

@@ sv/cpbc_merge.sv @@
// merge stage: packs lane bits into words, sums lane errors, updates totals
// depends on cpbc_pkg
module cpbc_merge import cpbc_pkg::*; #(
  parameter int TOTAL_WIDTH = TOTAL_WIDTH_DEF
) (
  input  lane_res_t              lanes [SYM_COUNT],
  input  logic [TOTAL_WIDTH-1:0] err_total,
  input  logic [TOTAL_WIDTH-1:0] bit_total,
  output word_t                  rx_word,
  output word_t                  exp_word,
  output werr_t                  word_errs,
  output logic [TOTAL_WIDTH-1:0] err_total_nxt,
  output logic [TOTAL_WIDTH-1:0] bit_total_nxt
);

  logic [TOTAL_WIDTH:0] err_sum;
  logic [TOTAL_WIDTH:0] bit_sum;

  // pack MSB first and add up lane mismatches
  always_comb begin
    rx_word   = '0;
    exp_word  = '0;
    word_errs = '0;
    for (int k = 0; k < SYM_COUNT; k++) begin
      rx_word[WORD_BITS-1-2*k -: 2]  = lanes[k].rx_bits;
      exp_word[WORD_BITS-1-2*k -: 2] = lanes[k].exp_bits;
      word_errs = word_errs + werr_t'(lanes[k].errs);
    end
  end

  // saturating totals: a carry out means the sum passed the maximum
  assign err_sum = {1'b0, err_total} + (TOTAL_WIDTH+1)'(word_errs);
  assign bit_sum = {1'b0, bit_total} + (TOTAL_WIDTH+1)'(WORD_BITS);

  assign err_total_nxt = err_sum[TOTAL_WIDTH] ? '1 : err_sum[TOTAL_WIDTH-1:0];
  assign bit_total_nxt = bit_sum[TOTAL_WIDTH] ? '1 : bit_sum[TOTAL_WIDTH-1:0];

endmodule

@@ sv/counter_pattern_ber_checker.sv @@
// top level of the counter pattern bit-error checker
// five symbol lanes, merge stage, pattern state and an output register
// depends on cpbc_pkg, cpbc_if, cpbc_lane, cpbc_merge
//
//   channel  dir  handshake            payload
//   in_ch    in   valid/ready          sym0_i..sym4_q, 16-bit signed each
//   out_ch   out  valid/ready          received/expected word, errors, totals
//
// one word per cycle unless out_ch stalls: a transfer on in_ch is decided, compared
// and counted in the cycle it arrives; the output register holds its result next cycle.
// the output register sets the figure: in_ch is ready while it is empty or drains.
// reset (rst_n low, synchronous) clears the pattern state, the totals and out valid.
// an out_ch stall holds the result and stops in_ch transfers until it is taken.
module counter_pattern_ber_checker import cpbc_pkg::*; #(
  parameter int TOTAL_WIDTH = TOTAL_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  cpbc_in_if.sink      in_ch,
  cpbc_out_if.source   out_ch
);

  sample_t   samp_i [SYM_COUNT];
  sample_t   samp_q [SYM_COUNT];
  lane_res_t lanes  [SYM_COUNT];

  word_t                  pattern_index_r;
  logic                   first_seen_r;
  logic [TOTAL_WIDTH-1:0] err_total_r;
  logic [TOTAL_WIDTH-1:0] bit_total_r;
  logic [TOTAL_WIDTH-1:0] err_total_nxt;
  logic [TOTAL_WIDTH-1:0] bit_total_nxt;

  word_t      rx_word;
  word_t      exp_word;
  werr_t      word_errs;
  logic       accept;

  logic       out_valid_r;
  word_t      out_rx_r;
  word_t      out_exp_r;
  werr_t      out_errs_r;
  logic       out_resync_r;
  out_total_t out_err_total_r;
  out_total_t out_bit_total_r;

  // samples per symbol lane
  assign samp_i[0] = in_ch.sym0_i;
  assign samp_q[0] = in_ch.sym0_q;
  assign samp_i[1] = in_ch.sym1_i;
  assign samp_q[1] = in_ch.sym1_q;
  assign samp_i[2] = in_ch.sym2_i;
  assign samp_q[2] = in_ch.sym2_q;
  assign samp_i[3] = in_ch.sym3_i;
  assign samp_q[3] = in_ch.sym3_q;
  assign samp_i[4] = in_ch.sym4_i;
  assign samp_q[4] = in_ch.sym4_q;

  // symbol lanes
  for (genvar k = 0; k < SYM_COUNT; k++) begin : g_lane
    cpbc_lane u_lane (
      .samp_i     (samp_i[k]),
      .samp_q     (samp_q[k]),
      .index_bits (pattern_index_r[WORD_BITS-1-2*k -: 2]),
      .first_seen (first_seen_r),
      .res        (lanes[k])
    );
  end

  // merge lanes and update totals
  cpbc_merge #(
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_merge (
    .lanes         (lanes),
    .err_total     (err_total_r),
    .bit_total     (bit_total_r),
    .rx_word       (rx_word),
    .exp_word      (exp_word),
    .word_errs     (word_errs),
    .err_total_nxt (err_total_nxt),
    .bit_total_nxt (bit_total_nxt)
  );

  // transfer when the output register is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // pattern state and totals; the next index is always received + 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_index_r <= '0;
      first_seen_r    <= 1'b0;
      err_total_r     <= '0;
      bit_total_r     <= '0;
    end else if (accept) begin
      pattern_index_r <= rx_word + word_t'(1);
      first_seen_r    <= 1'b1;
      err_total_r     <= err_total_nxt;
      bit_total_r     <= bit_total_nxt;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_rx_r        <= rx_word;
      out_exp_r       <= exp_word;
      out_errs_r      <= word_errs;
      out_resync_r    <= (word_errs != '0);
      out_err_total_r <= OUT_TOTAL_W'(err_total_nxt);
      out_bit_total_r <= OUT_TOTAL_W'(bit_total_nxt);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.received_word = out_rx_r;
  assign out_ch.expected_word = out_exp_r;
  assign out_ch.word_errors   = out_errs_r;
  assign out_ch.resynced      = out_resync_r;
  assign out_ch.error_total   = out_err_total_r;
  assign out_ch.bit_total     = out_bit_total_r;

  // checks

  // a transfer always lands in the output register
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted word did not reach the output register");

  // the pattern index follows the last received word
  a_index_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (pattern_index_r == out_rx_r + word_t'(1)))
    else $error("pattern index does not follow received word");

  // a resync is reported exactly when the word had errors
  a_resync_errs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_resync_r == (out_errs_r != '0)))
    else $error("resync flag disagrees with word errors");

  // the bit total never goes backwards
  a_bits_mono: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (bit_total_r >= $past(bit_total_r)))
    else $error("bit total decreased");

endmodule

@@ tb/sv/counter_pattern_ber_checker_test.sv @@
// self-checking bench for the counter pattern bit-error checker
// a directed table then random slots, checked against an in-bench pattern tracker
// depends on cpbc_pkg, cpbc_if and counter_pattern_ber_checker
module counter_pattern_ber_checker_test import cpbc_pkg::*;;

  localparam int TOTAL_W   = 32;
  localparam int SAMPLES   = 2 * SYM_COUNT;
  localparam int RAND_SLOTS = 1650;
  localparam logic [63:0] TOTAL_MAX = (64'd1 << TOTAL_W) - 64'd1;

  typedef logic [SAMPLES-1:0][SAMPLE_W-1:0] sym_pack_t;

  typedef struct packed {
    word_t      rx;
    word_t      expw;
    werr_t      errs;
    logic       resync;
    out_total_t err_tot;
    out_total_t bit_tot;
  } slot_res_t;

  // one directed slot: word sent with fixed one/zero amplitudes
  typedef struct packed {
    word_t     word;
    sample_t   one_amp;
    sample_t   zero_amp;
    bit        known;
    slot_res_t res;
  } dir_row_t;

  localparam slot_res_t NO_RES = '0;
  localparam int DIR_ROWS = 16;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // first slot locks onto whatever arrives
    '{10'h3FF, 16'sd5792, -16'sd10000, 1'b1, '{10'h3FF, 10'h3FF, 4'd0, 1'b0, 32'd0, 32'd10}},
    // index wraps from 1023 to 0
    '{10'h000, 16'sd5792, -16'sd5792, 1'b1, '{10'h000, 10'h000, 4'd0, 1'b0, 32'd0, 32'd20}},
    // zero sample decides to one
    '{10'h001, 16'sh0000, 16'sh8000, 1'b1, '{10'h001, 10'h001, 4'd0, 1'b0, 32'd0, 32'd30}},
    '{10'h3FF, 16'sh0000, -16'sd1, 1'b1, '{10'h3FF, 10'h002, 4'd9, 1'b1, 32'd9, 32'd40}},
    // every bit wrong, full-scale samples
    '{10'h3FF, 16'sh7FFF, 16'sh8000, 1'b1, '{10'h3FF, 10'h000, 4'd10, 1'b1, 32'd19, 32'd50}},
    '{10'h000, 16'sd1, -16'sd1, 1'b1, '{10'h000, 10'h000, 4'd0, 1'b0, 32'd19, 32'd60}},
    '{10'h000, 16'sh7FFF, 16'sh8000, 1'b1, '{10'h000, 10'h001, 4'd1, 1'b1, 32'd20, 32'd70}},
    '{10'h001, 16'sd5792, -16'sd10000, 1'b1, '{10'h001, 10'h001, 4'd0, 1'b0, 32'd20, 32'd80}},
    '{10'h2AA, 16'sh7FFF, 16'sh8000, 1'b1, '{10'h2AA, 10'h002, 4'd4, 1'b1, 32'd24, 32'd90}},
    '{10'h2AB, 16'sd1, -16'sd1, 1'b1, '{10'h2AB, 10'h2AB, 4'd0, 1'b0, 32'd24, 32'd100}},
    '{10'h2AC, 16'sd5792, -16'sd5792, 1'b0, NO_RES},
    '{10'h2AD, 16'sd3000, -16'sd20000, 1'b0, NO_RES},
    '{10'h3FE, 16'sd5792, -16'sd5792, 1'b0, NO_RES},
    '{10'h3FF, 16'sh0000, 16'sh8000, 1'b0, NO_RES},
    '{10'h000, 16'sh7FFF, -16'sd1, 1'b0, NO_RES},
    '{10'h155, 16'sd5792, -16'sd10000, 1'b0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst_n;

  cpbc_in_if  in_ch ();
  cpbc_out_if out_ch ();

  counter_pattern_ber_checker #(
    .TOTAL_WIDTH(TOTAL_W)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #1 clk = ~clk;

  // pattern tracker state
  word_t       pat_index = '0;
  bit          pat_seen  = 1'b0;
  logic [63:0] err_sum   = '0;
  logic [63:0] bit_sum   = '0;

  slot_res_t pending_slots[$];
  int        mismatches = 0;
  bit        in_burst   = 1'b0;
  bit        out_burst  = 1'b0;

  // hard-decide one slot, compare with the pattern and advance the tracker
  function automatic slot_res_t predict_slot(sym_pack_t syms);
    word_t     rx;
    word_t     expw;
    int        errs;
    slot_res_t r;
    for (int k = 0; k < SAMPLES; k++) begin
      rx[SAMPLES-1-k] = ~syms[k][SAMPLE_W-1];
    end
    if (!pat_seen) begin
      expw     = rx;
      pat_seen = 1'b1;
    end else begin
      expw = pat_index;
    end
    errs      = $countones(rx ^ expw);
    pat_index = (errs == 0) ? word_t'(expw + 1'b1) : word_t'(rx + 1'b1);
    err_sum   = (err_sum + errs > TOTAL_MAX) ? TOTAL_MAX : err_sum + errs;
    bit_sum   = (bit_sum + WORD_BITS > TOTAL_MAX) ? TOTAL_MAX : bit_sum + WORD_BITS;
    r.rx      = rx;
    r.expw    = expw;
    r.errs    = werr_t'(errs);
    r.resync  = (errs != 0);
    r.err_tot = err_sum[OUT_TOTAL_W-1:0];
    r.bit_tot = bit_sum[OUT_TOTAL_W-1:0];
    return r;
  endfunction

  // noisy sample on the right side of zero for one bit
  function automatic sample_t draw_sample(bit b);
    case ($urandom_range(0, 7))
      0: return b ? 16'sh0000 : -16'sd1;
      1: return b ? 16'sh7FFF : 16'sh8000;
      2: return b ? 16'sd5792 : -16'sd5792;
      3: return b ? 16'sd5792 : -16'sd10000;
      default: begin
        if (b) return sample_t'($urandom_range(0, 32767));
        return sample_t'(-int'($urandom_range(1, 32768)));
      end
    endcase
  endfunction

  // map a word onto the ten samples, MSB on symbol 0 I
  function automatic sym_pack_t encode_word(word_t w, bit fixed, sample_t one_amp,
                                            sample_t zero_amp);
    sym_pack_t syms;
    bit        b;
    for (int k = 0; k < SAMPLES; k++) begin
      b       = w[SAMPLES-1-k];
      syms[k] = fixed ? (b ? one_amp : zero_amp) : draw_sample(b);
    end
    return syms;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // offer one slot, wait for its transfer and queue what it should produce
  task automatic drive_slot(sym_pack_t syms, bit known, slot_res_t known_res);
    int        gap;
    slot_res_t want;
    gap = in_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sym0_i <= syms[0];
    in_ch.sym0_q <= syms[1];
    in_ch.sym1_i <= syms[2];
    in_ch.sym1_q <= syms[3];
    in_ch.sym2_i <= syms[4];
    in_ch.sym2_q <= syms[5];
    in_ch.sym3_i <= syms[6];
    in_ch.sym3_q <= syms[7];
    in_ch.sym4_i <= syms[8];
    in_ch.sym4_q <= syms[9];
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    want = predict_slot(syms);
    pending_slots.push_back(known ? known_res : want);
  endtask

  // stimulus
  initial begin
    sym_pack_t syms;
    word_t     word;
    int        pick;
    int        flips;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.sym0_i = '0;
    in_ch.sym0_q = '0;
    in_ch.sym1_i = '0;
    in_ch.sym1_q = '0;
    in_ch.sym2_i = '0;
    in_ch.sym2_q = '0;
    in_ch.sym3_i = '0;
    in_ch.sym3_q = '0;
    in_ch.sym4_i = '0;
    in_ch.sym4_q = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      syms = encode_word(DIR_TABLE[i].word, 1'b1, DIR_TABLE[i].one_amp, DIR_TABLE[i].zero_amp);
      drive_slot(syms, DIR_TABLE[i].known, DIR_TABLE[i].res);
    end

    // random slots: mostly the running count, some with bit errors or noise
    for (int n = 0; n < RAND_SLOTS; n++) begin
      if (n % 50 == 0) in_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      word = pat_index;
      if (pick >= 65 && pick < 80) begin
        flips = $urandom_range(1, 3);
        repeat (flips) word[$urandom_range(0, WORD_BITS - 1)] ^= 1'b1;
      end else if (pick >= 80) begin
        word = word_t'($urandom);
      end
      syms = encode_word(word, 1'b0, '0, '0);
      if (pick >= 92) begin
        for (int k = 0; k < SAMPLES; k++) syms[k] = SAMPLE_W'($urandom);
      end
      drive_slot(syms, 1'b0, NO_RES);
    end
    in_ch.valid <= 1'b0;

    // drain, then allow the output register to settle
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side: random stalls, compare each transfer with the oldest slot
  initial begin
    slot_res_t got;
    slot_res_t want;
    int        stall;
    int        taken;
    taken        = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken % 50 == 0) out_burst = ($urandom_range(0, 3) == 0);
      stall = out_burst ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(negedge clk); while (out_ch.valid !== 1'b1);
      got.rx      = out_ch.received_word;
      got.expw    = out_ch.expected_word;
      got.errs    = out_ch.word_errors;
      got.resync  = out_ch.resynced;
      got.err_tot = out_ch.error_total;
      got.bit_tot = out_ch.bit_total;
      @(posedge clk);
      taken++;
      if (pending_slots.size() == 0) begin
        $error("result transfer with no slot pending");
        mismatches++;
      end else begin
        want = pending_slots.pop_front();
        check_field("received_word", want.rx, got.rx);
        check_field("expected_word", want.expw, got.expw);
        check_field("word_errors", want.errs, got.errs);
        check_field("resynced", want.resync, got.resync);
        check_field("error_total", want.err_tot, got.err_tot);
        check_field("bit_total", want.bit_tot, got.bit_tot);
      end
    end
  end

  // watchdog
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
